// ----- design/stepper_phase_sequencer_assert.svh -----
// Assertion macros for the stepper phase sequencer checker
`ifndef STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sps_pkg.sv -----
// Shared types, constants and phase tables for the stepper phase sequencer
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

    localparam int unsigned SPR_W   = 12;
    localparam int unsigned DEG_W   = 16;
    localparam int unsigned DLY_W   = 16;
    localparam int unsigned PROD_W  = 28;
    localparam int unsigned STEPS_W = 21;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned PAT_W   = 4;

    localparam logic [SPR_W-1:0] SPR_RESET = 12'd200;
    localparam int unsigned QDEPTH_DEF = 4;

    // prod/180 = (prod>>2)/45, prod/360 = (prod>>3)/45
    localparam int unsigned DIVX_W      = 26;
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned MULQ_W      = DIVX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443717; // floor(2^32 / 45)
    localparam logic [DIVX_W:0]    DIV_45   = 27'd45;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_MOVE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               dir;
        logic               half;
        logic [DLY_W-1:0]   dly;
        logic [STEPS_W-1:0] nsteps;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qwr;

    function automatic logic [PAT_W-1:0] half_pattern(input logic [2:0] idx);
        logic [PAT_W-1:0] p;
        case (idx)
            3'd0:    p = 4'h2;
            3'd1:    p = 4'h6;
            3'd2:    p = 4'h4;
            3'd3:    p = 4'h5;
            3'd4:    p = 4'h1;
            3'd5:    p = 4'h9;
            3'd6:    p = 4'h8;
            3'd7:    p = 4'hA;
            default: p = 4'h0;
        endcase
        return p;
    endfunction

    function automatic logic [PAT_W-1:0] full_pattern(input logic [1:0] idx);
        logic [PAT_W-1:0] p;
        case (idx)
            2'd0:    p = 4'h2;
            2'd1:    p = 4'h4;
            2'd2:    p = 4'h1;
            2'd3:    p = 4'h8;
            default: p = 4'h0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- design/sps_front.sv -----
// Front end: config register, beat intake and step-count pipeline
`timescale 1ns / 1ps
`default_nettype none
module sps_front
    import sps_pkg::*;
#(
    parameter int unsigned P_QDEPTH = QDEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(P_QDEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [SPR_W-1:0] i_cfg_wdata,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             i_operation,
    input  wire logic             i_direction,
    input  wire logic [DEG_W-1:0] i_degrees,
    input  wire logic             i_half_step,
    input  wire logic [DLY_W-1:0] i_step_delay,
    input  wire logic [CNT_W-1:0] i_q_count,
    output t_qwr                  o_wr
);

    logic [SPR_W-1:0] r_spr;

    logic              r_s1_v;
    t_op               r_s1_op;
    logic              r_s1_dir;
    logic              r_s1_half;
    logic [DLY_W-1:0]  r_s1_dly;
    logic [PROD_W-1:0] r_s1_prod;

    logic               r_s2_v;
    t_op                r_s2_op;
    logic               r_s2_dir;
    logic               r_s2_half;
    logic [DLY_W-1:0]   r_s2_dly;
    logic [DIVX_W-1:0]  r_s2_x;
    logic [STEPS_W-1:0] r_s2_qe;

    logic               accept;
    logic [CNT_W:0]     occ;
    logic [PROD_W-1:0]  n_prod;
    logic [DIVX_W-1:0]  n_x;
    logic [MULQ_W-1:0]  mulq;
    logic [DIVX_W:0]    qe45;
    logic [DIVX_W:0]    rem;
    logic [STEPS_W-1:0] nsteps;

    // in-flight beats reserve queue space so the pipeline never stalls
    assign occ = {1'b0, i_q_count} + (CNT_W + 1)'(r_s1_v) + (CNT_W + 1)'(r_s2_v);
    assign full   = occ >= (CNT_W + 1)'(P_QDEPTH);
    assign accept = push && !full;

    assign n_prod = PROD_W'(i_degrees) * PROD_W'(r_spr);
    assign n_x    = r_s1_half ? r_s1_prod[PROD_W-1:2] : {1'b0, r_s1_prod[PROD_W-1:3]};
    assign mulq   = MULQ_W'(n_x) * MULQ_W'(RECIP_45);

    // estimate is exact or one short
    assign qe45   = (DIVX_W + 1)'(r_s2_qe) * DIV_45;
    assign rem    = {1'b0, r_s2_x} - qe45;
    assign nsteps = r_s2_qe + STEPS_W'(rem >= DIV_45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr  <= SPR_RESET;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_spr <= i_cfg_wdata;
            end
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_dir  <= i_direction;
            r_s1_half <= i_half_step;
            r_s1_dly  <= i_step_delay;
            r_s1_prod <= n_prod;
        end
        if (r_s1_v) begin
            r_s2_op   <= r_s1_op;
            r_s2_dir  <= r_s1_dir;
            r_s2_half <= r_s1_half;
            r_s2_dly  <= r_s1_dly;
            r_s2_x    <= n_x;
            r_s2_qe   <= mulq[RECIP_SHIFT +: STEPS_W];
        end
    end

    always_comb begin
        o_wr.valid       = r_s2_v;
        o_wr.item.op     = r_s2_op;
        o_wr.item.dir    = r_s2_dir;
        o_wr.item.half   = r_s2_half;
        o_wr.item.dly    = r_s2_dly;
        o_wr.item.nsteps = nsteps;
    end

endmodule
`default_nettype wire

// ----- design/sps_queue.sv -----
// Short queue between the front end and the step executor
`timescale 1ns / 1ps
`default_nettype none
module sps_queue
    import sps_pkg::*;
#(
    parameter int unsigned P_QDEPTH = QDEPTH_DEF,
    localparam int unsigned CNT_W = $clog2(P_QDEPTH + 1),
    localparam int unsigned PTR_W = $clog2(P_QDEPTH)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_qwr  i_wr,
    input  wire logic  i_rd,
    output logic [CNT_W-1:0] o_count,
    output logic       o_empty,
    output t_item      o_head
);

    t_item            r_mem [P_QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             rd;

    assign o_count = r_count;
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign rd      = i_rd && !o_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(P_QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (rd) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_wr.valid && !rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr.valid && rd) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wptr] <= i_wr.item;
        end
    end

endmodule
`default_nettype wire

// ----- design/sps_back.sv -----
// Step executor: phase index, step and wait counters, result register
`timescale 1ns / 1ps
`default_nettype none
module sps_back
    import sps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_head,
    input  wire logic  i_q_empty,
    output logic       o_rd,
    output logic       empty,
    input  wire logic  pop,
    output logic [PAT_W-1:0] o_phase_pattern,
    output logic       o_stepped,
    output logic       o_busy_res,
    output logic       o_rejected
);

    logic [IDX_W-1:0]   r_idx,    n_idx;
    logic [STEPS_W-1:0] r_steps,  n_steps;
    logic [DLY_W-1:0]   r_wait,   n_wait;
    logic [DLY_W-1:0]   r_reload, n_reload;
    logic               r_rev,    n_rev;
    logic               r_half,   n_half;
    logic [PAT_W-1:0]   r_pat,    n_pat;

    logic r_ov;
    logic r_o_stepped;
    logic r_o_busy;
    logic r_o_rej;

    logic take;
    logic busy;
    logic do_step;
    logic stepped;
    logic rej;

    assign take  = !i_q_empty && (!r_ov || pop);
    assign o_rd  = take;
    assign empty = !r_ov;
    assign busy  = (r_steps != '0) || (r_wait != '0);

    always_comb begin
        n_steps  = r_steps;
        n_wait   = r_wait;
        n_reload = r_reload;
        n_rev    = r_rev;
        n_half   = r_half;
        do_step  = 1'b0;
        rej      = 1'b0;
        case (i_head.op)
            OP_MOVE: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_rev    = i_head.dir;
                    n_half   = i_head.half;
                    n_reload = i_head.dly;
                    if (i_head.nsteps != '0) begin
                        do_step = 1'b1;
                        n_steps = i_head.nsteps - STEPS_W'(1);
                        n_wait  = i_head.dly;
                    end
                end
            end
            OP_TICK: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - DLY_W'(1);
                end else if (r_steps != '0) begin
                    do_step = 1'b1;
                    n_steps = r_steps - STEPS_W'(1);
                    n_wait  = r_reload;
                end
            end
            default: ;
        endcase
        stepped = do_step;
    end

    // drive the pattern at the current index, then walk it with wrap
    always_comb begin
        n_idx = r_idx;
        n_pat = r_pat;
        if (do_step) begin
            if (n_half) begin
                n_pat = half_pattern(r_idx);
                n_idx = n_rev ? r_idx - IDX_W'(1) : r_idx + IDX_W'(1);
            end else begin
                n_pat = full_pattern(r_idx[1:0]);
                n_idx = {1'b0, n_rev ? r_idx[1:0] - 2'd1 : r_idx[1:0] + 2'd1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_steps  <= '0;
            r_wait   <= '0;
            r_reload <= '0;
            r_rev    <= 1'b0;
            r_half   <= 1'b0;
            r_pat    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (take) begin
                r_idx    <= n_idx;
                r_steps  <= n_steps;
                r_wait   <= n_wait;
                r_reload <= n_reload;
                r_rev    <= n_rev;
                r_half   <= n_half;
                r_pat    <= n_pat;
                r_ov     <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_stepped <= stepped;
            r_o_busy    <= (n_steps != '0) || (n_wait != '0);
            r_o_rej     <= rej;
        end
    end

    assign o_phase_pattern = r_pat;
    assign o_stepped       = r_o_stepped;
    assign o_busy_res      = r_o_busy;
    assign o_rejected      = r_o_rej;

endmodule
`default_nettype wire

// ----- design/stepper_phase_sequencer.sv -----
// Stepper phase sequencer: top level joining front end, queue and executor
// Throughput: one beat per cycle, ticks and move commands alike, while full stays low.
// Path: a taken beat passes the product register, the reciprocal multiply register,
// the queue entry and the result register; it waits in the queue while results stall.
// Reset: synchronous active-low; coils off, counters clear, steps_per_rev 200,
// queue and result register empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module stepper_phase_sequencer
    import sps_pkg::*;
#(
    parameter int unsigned P_QDEPTH = QDEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [SPR_W-1:0] i_cfg_wdata,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             i_operation,
    input  wire logic             i_direction,
    input  wire logic [DEG_W-1:0] i_degrees,
    input  wire logic             i_half_step,
    input  wire logic [DLY_W-1:0] i_step_delay,
    output logic                  empty,
    input  wire logic             pop,
    output logic [PAT_W-1:0]      o_phase_pattern,
    output logic                  o_stepped,
    output logic                  o_busy_res,
    output logic                  o_rejected
);

    localparam int unsigned CNT_W = $clog2(P_QDEPTH + 1);

    t_qwr             wr;
    t_item            head;
    logic [CNT_W-1:0] q_count;
    logic             q_empty;
    logic             q_rd;

    sps_front #(.P_QDEPTH(P_QDEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_direction  (i_direction),
        .i_degrees    (i_degrees),
        .i_half_step  (i_half_step),
        .i_step_delay (i_step_delay),
        .i_q_count    (q_count),
        .o_wr         (wr)
    );

    sps_queue #(.P_QDEPTH(P_QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (q_rd),
        .o_count (q_count),
        .o_empty (q_empty),
        .o_head  (head)
    );

    sps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_empty       (q_empty),
        .o_rd            (q_rd),
        .empty           (empty),
        .pop             (pop),
        .o_phase_pattern (o_phase_pattern),
        .o_stepped       (o_stepped),
        .o_busy_res      (o_busy_res),
        .o_rejected      (o_rejected)
    );

endmodule
`default_nettype wire

// ----- design/sps_checker.sv -----
// Port-level checker for the stepper phase sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_phase_sequencer_assert.svh"
module sps_checker
    import sps_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_we,
    input wire logic [SPR_W-1:0] i_cfg_wdata,
    input wire logic             push,
    input wire logic             full,
    input wire logic             i_operation,
    input wire logic             i_direction,
    input wire logic [DEG_W-1:0] i_degrees,
    input wire logic             i_half_step,
    input wire logic [DLY_W-1:0] i_step_delay,
    input wire logic             empty,
    input wire logic             pop,
    input wire logic [PAT_W-1:0] o_phase_pattern,
    input wire logic             o_stepped,
    input wire logic             o_busy_res,
    input wire logic             o_rejected
);

    // a stalled result beat holds
    `SPS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_phase_pattern) && $stable(o_stepped) && $stable(o_busy_res) && $stable(o_rejected), "result beat changed while stalled")
    // a rejected command drives nothing
    `SPS_ASSERT_NOW(a_rej_nostep, !empty && o_rejected, !o_stepped, "rejected command stepped")
    // a driven step always energises a coil
    `SPS_ASSERT_NOW(a_step_pat, !empty && o_stepped, o_phase_pattern != 4'h0, "step drove no coil")
    // opposing coil pairs never on together
    `SPS_ASSERT_NOW(a_no_short, !empty, !(&o_phase_pattern[1:0]) && !(&o_phase_pattern[3:2]), "opposing coils both driven")

endmodule

bind stepper_phase_sequencer sps_checker u_sps_checker (.*);
`default_nettype wire

// ----- tb/stepper_phase_sequencer_checker.sv -----
// Scoreboard for the stepper phase sequencer: predicts each result beat and compares it
`timescale 1ns / 1ps
module stepper_phase_sequencer_checker
    import sps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [SPR_W-1:0] i_cfg_wdata,
    input  wire logic             i_push,
    input  wire logic             i_full,
    input  wire logic             i_operation,
    input  wire logic             i_direction,
    input  wire logic [DEG_W-1:0] i_degrees,
    input  wire logic             i_half_step,
    input  wire logic [DLY_W-1:0] i_step_delay,
    input  wire logic             i_empty,
    input  wire logic             i_pop,
    input  wire logic [PAT_W-1:0] i_phase_pattern,
    input  wire logic             i_stepped,
    input  wire logic             i_busy_res,
    input  wire logic             i_rejected,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_steps,
    output int                    o_rejects
);

    localparam int MAX_REPORTS = 10;
    localparam int DIV_HALF    = 180;
    localparam int DIV_FULL    = 360;
    // coil patterns, entry 0 in the low nibble
    localparam logic [31:0] HALF_SEQ = {4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6, 4'h2};
    localparam logic [15:0] FULL_SEQ = {4'h8, 4'h1, 4'h4, 4'h2};

    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic             stepped;
        logic             busy;
        logic             rejected;
    } t_coil_beat;

    t_coil_beat         coil_due_q[$];
    logic [SPR_W-1:0]   spr;
    logic [IDX_W-1:0]   phase_idx;
    logic [STEPS_W-1:0] steps_left;
    logic [DLY_W-1:0]   wait_cnt;
    logic [DLY_W-1:0]   dly_reload;
    logic               move_rev;
    logic               move_half;
    logic [PAT_W-1:0]   coils;
    int                 fails;
    int                 beats_out;
    int                 steps_seen;
    int                 rejects_seen;

    function automatic void drive_coils();
        logic [IDX_W-1:0] mask;
        logic [IDX_W-1:0] cur;
        mask  = move_half ? 3'd7 : 3'd3;
        cur   = phase_idx & mask;
        coils = move_half ? HALF_SEQ[4*cur +: 4] : FULL_SEQ[4*cur[1:0] +: 4];
        cur   = (move_rev ? cur + mask : cur + 3'd1) & mask;
        phase_idx = cur;
    endfunction

    function automatic t_coil_beat sequencer_step(input t_op op, input logic dir,
                                                  input logic [DEG_W-1:0] deg,
                                                  input logic half,
                                                  input logic [DLY_W-1:0] dly);
        t_coil_beat        r;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] n;
        r = '0;
        if (op == OP_MOVE) begin
            if (steps_left != 0 || wait_cnt != 0) begin
                r.rejected = 1'b1;
            end else begin
                prod       = PROD_W'(deg) * PROD_W'(spr);
                n          = PROD_W'(prod / (half ? DIV_HALF : DIV_FULL));
                move_rev   = dir;
                move_half  = half;
                dly_reload = dly;
                if (n != 0) begin
                    drive_coils();
                    r.stepped  = 1'b1;
                    steps_left = STEPS_W'(n - 1);
                    wait_cnt   = dly;
                end
            end
        end else if (wait_cnt != 0) begin
            wait_cnt = wait_cnt - 1'b1;
        end else if (steps_left != 0) begin
            drive_coils();
            r.stepped  = 1'b1;
            steps_left = steps_left - 1'b1;
            wait_cnt   = dly_reload;
        end
        r.pattern = coils;
        r.busy    = (steps_left != 0) || (wait_cnt != 0);
        return r;
    endfunction

    function automatic void log_fail(input string what, input t_coil_beat want,
                                     input t_coil_beat got);
        if (fails < MAX_REPORTS) begin
            $display("%0t: %s: exp pattern=%h stepped=%b busy=%b rejected=%b",
                     $realtime, what, want.pattern, want.stepped, want.busy, want.rejected);
            $display("    got pattern=%h stepped=%b busy=%b rejected=%b",
                     got.pattern, got.stepped, got.busy, got.rejected);
        end
        fails++;
    endfunction

    always @(posedge i_clk) begin
        t_coil_beat got;
        t_coil_beat want;
        if (!i_rst_n) begin
            coil_due_q.delete();
            spr          = SPR_RESET;
            phase_idx    = '0;
            steps_left   = '0;
            wait_cnt     = '0;
            dly_reload   = '0;
            move_rev     = 1'b0;
            move_half    = 1'b0;
            coils        = '0;
            fails        = 0;
            beats_out    = 0;
            steps_seen   = 0;
            rejects_seen = 0;
        end else begin
            if (i_cfg_we) begin
                spr = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                coil_due_q.push_back(sequencer_step(t_op'(i_operation), i_direction,
                                                    i_degrees, i_half_step, i_step_delay));
            end
            if (i_pop && !i_empty) begin
                got = '{i_phase_pattern, i_stepped, i_busy_res, i_rejected};
                beats_out++;
                if (coil_due_q.size() == 0) begin
                    log_fail("unexpected result beat", '0, got);
                end else begin
                    want = coil_due_q.pop_front();
                    if (got.pattern !== want.pattern || got.stepped !== want.stepped ||
                        got.busy !== want.busy || got.rejected !== want.rejected) begin
                        log_fail("result mismatch", want, got);
                    end
                    steps_seen   += int'(want.stepped);
                    rejects_seen += int'(want.rejected);
                end
            end
        end
        o_errors  <= fails;
        o_pending <= coil_due_q.size();
        o_results <= beats_out;
        o_steps   <= steps_seen;
        o_rejects <= rejects_seen;
    end

endmodule

// ----- tb/tb_stepper_phase_sequencer.sv -----
// Testbench top for the stepper phase sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_stepper_phase_sequencer;
    import sps_pkg::*;

    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int STEP_CAP      = 16;
    localparam int DIV_HALF      = 180;
    localparam int DIV_FULL      = 360;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [SPR_W-1:0] cfg_wdata = '0;
    logic             push      = 1'b0;
    logic             pop       = 1'b0;
    logic             in_op     = 1'b0;
    logic             in_dir    = 1'b0;
    logic [DEG_W-1:0] in_deg    = '0;
    logic             in_half   = 1'b0;
    logic [DLY_W-1:0] in_dly    = '0;
    logic             full;
    logic             empty;
    logic [PAT_W-1:0] phase_pattern;
    logic             stepped;
    logic             busy_res;
    logic             rejected;

    int               tx_idle_pct = 24;
    int               rx_idle_pct = 55;
    logic             hold_req    = 1'b0;
    logic [SPR_W-1:0] spr_now     = SPR_RESET;
    int               beats_in    = 0;
    int               moves_in    = 0;
    int               n_settings  = 0;
    int               errors;
    int               pending;
    int               results;
    int               steps;
    int               rejects;

    always #2 i_clk = ~i_clk;

    stepper_phase_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .push            (push),
        .full            (full),
        .i_operation     (in_op),
        .i_direction     (in_dir),
        .i_degrees       (in_deg),
        .i_half_step     (in_half),
        .i_step_delay    (in_dly),
        .empty           (empty),
        .pop             (pop),
        .o_phase_pattern (phase_pattern),
        .o_stepped       (stepped),
        .o_busy_res      (busy_res),
        .o_rejected      (rejected)
    );

    stepper_phase_sequencer_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_push          (push),
        .i_full          (full),
        .i_operation     (in_op),
        .i_direction     (in_dir),
        .i_degrees       (in_deg),
        .i_half_step     (in_half),
        .i_step_delay    (in_dly),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_phase_pattern (phase_pattern),
        .i_stepped       (stepped),
        .i_busy_res      (busy_res),
        .i_rejected      (rejected),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_results       (results),
        .o_steps         (steps),
        .o_rejects       (rejects)
    );

    function automatic logic rnd_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // ticks needed after an accepted move until the block is idle again
    function automatic int ticks_for(input logic [DEG_W-1:0] deg, input logic half,
                                     input logic [DLY_W-1:0] dly);
        longint n;
        n = (longint'(deg) * longint'(spr_now)) / (half ? DIV_HALF : DIV_FULL);
        return (n == 0) ? 0 : int'((n - 1) * (longint'(dly) + 1) + longint'(dly));
    endfunction

    task automatic send_beat(input t_op op, input logic dir, input logic [DEG_W-1:0] deg,
                             input logic half, input logic [DLY_W-1:0] dly);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_op   <= op;
        in_dir  <= dir;
        in_deg  <= deg;
        in_half <= half;
        in_dly  <= dly;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_in++;
        if (op == OP_MOVE) moves_in++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(OP_TICK, rnd_bit(), rnd16(), rnd_bit(), rnd16());
    endtask

    // move from idle, ticks to completion; some commands land mid-move and bounce
    task automatic move_and_run(input logic dir, input logic [DEG_W-1:0] deg,
                                input logic half, input logic [DLY_W-1:0] dly,
                                input int bounce_pct);
        int need;
        int j;
        need = ticks_for(deg, half, dly);
        send_beat(OP_MOVE, dir, deg, half, dly);
        for (j = 0; j < need + int'($urandom_range(2)); j++) begin
            if (j < need && $urandom_range(99) < bounce_pct)
                send_beat(OP_MOVE, rnd_bit(), rnd16(), rnd_bit(), rnd16());
            send_beat(OP_TICK, rnd_bit(), rnd16(), rnd_bit(), rnd16());
        end
    endtask

    task automatic run_sequence();
        int               kind;
        int               max_deg;
        logic             half;
        logic [DLY_W-1:0] dly;
        kind = $urandom_range(99);
        if (kind < 12) begin
            if (rnd_bit())
                send_beat(OP_TICK, rnd_bit(), rnd16(), rnd_bit(), rnd16());
            else
                send_beat(OP_MOVE, rnd_bit(), '0, rnd_bit(), rnd16());
            return;
        end
        half    = rnd_bit();
        max_deg = (spr_now == 0) ? 65535 :
                  (STEP_CAP * (half ? DIV_HALF : DIV_FULL)) / int'(spr_now);
        if (max_deg < 1) max_deg = 1;
        if (max_deg > 65535) max_deg = 65535;
        dly = ($urandom_range(99) < 75) ? 16'($urandom_range(3)) : 16'($urandom_range(12, 4));
        move_and_run(rnd_bit(), 16'($urandom_range(max_deg)), half, dly,
                     (kind < 30) ? 25 : 3);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        push <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    task automatic set_spr(input logic [SPR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we  <= 1'b0;
        spr_now = v;
        n_settings++;
    endtask

    task automatic random_phase(input logic [SPR_W-1:0] v, input int quota);
        int goal;
        drain();
        set_spr(v);
        goal = beats_in + quota;
        while (beats_in < goal) run_sequence();
    endtask

    // result side
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge i_clk);
        end
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, default steps/rev written explicitly
        set_spr(SPR_RESET);
        send_beat(OP_TICK, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_beat(OP_MOVE, 1'b1, 16'd0, 1'b1, 16'hFFFF);
        send_beat(OP_MOVE, 1'b0, 16'd1, 1'b1, 16'd0);
        send_beat(OP_MOVE, 1'b0, 16'd1, 1'b0, 16'd0);
        send_beat(OP_MOVE, 1'b1, 16'd9, 1'b0, 16'd1);
        send_beat(OP_MOVE, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_ticks(9);
        send_beat(OP_MOVE, 1'b1, 16'd4, 1'b1, 16'd0);
        send_ticks(4);
        send_beat(OP_MOVE, 1'b0, 16'd7, 1'b0, 16'd0);
        send_ticks(3);
        begin : phase_default
            int goal;
            goal = beats_in + 150;
            while (beats_in < goal) run_sequence();
        end

        // largest steps/rev, plus a long receiver hold-off so the input stalls
        drain();
        set_spr(12'd4095);
        hold_req = 1'b1;
        move_and_run(1'b0, 16'd2, 1'b1, 16'd0, 2);
        random_phase(12'd4095, 200);

        tx_idle_pct = 55;
        rx_idle_pct = 24;
        drain();
        set_spr(12'd1);
        move_and_run(1'b1, 16'hFFFF, 1'b0, 16'd0, 2);
        random_phase(12'd1, 180);
        random_phase(12'd0, 80);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(12'($urandom_range(4095, 1)), 180);
        random_phase(12'd12, 150);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d input beats (%0d moves, %0d bounced as busy), %0d steps/rev values;",
                 beats_in, moves_in, rejects, n_settings);
        $display("%0d result beats checked, %0d of them driving a new coil pattern.",
                 results, steps);
        if (pending != 0)
            $display("%0d expected result beats never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/sps_pkg.sv
design/sps_front.sv
design/sps_queue.sv
design/sps_back.sv
design/stepper_phase_sequencer.sv
design/sps_checker.sv
tb/stepper_phase_sequencer_checker.sv
tb/tb_stepper_phase_sequencer.sv
